@@ rtl/selective_repeat_sender_aimd_defines.svh @@
// Assertion macros for the selective repeat sender.
// Uses clk_i and rst_ni of the module that includes this header.
`ifndef SELECTIVE_REPEAT_SENDER_AIMD_DEFINES_SVH
`define SELECTIVE_REPEAT_SENDER_AIMD_DEFINES_SVH

// same-cycle implication
`define SRS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SRS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/srs_pkg.sv @@
// Shared types and constants for the selective repeat sender.
// No dependencies.
package srs_pkg;

  localparam int unsigned SLOTS   = 32;
  localparam int unsigned IDX_W   = $clog2(SLOTS);
  localparam int unsigned SEQ_W   = 32;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned WIN_W   = 6;
  localparam int unsigned CNT_W   = 6;
  localparam int unsigned TO_W    = 16;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned CFG_W   = 32;
  localparam int unsigned CFG_A_W = 2;
  // input queue depth, power of two
  localparam int unsigned QDEPTH  = 2;
  localparam int unsigned QPTR_W  = $clog2(QDEPTH);
  localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [CFG_A_W-1:0] REG_TOTAL_CHUNKS   = 2'd0;
  localparam logic [CFG_A_W-1:0] REG_INITIAL_WINDOW = 2'd1;
  localparam logic [CFG_A_W-1:0] REG_MAX_WINDOW     = 2'd2;
  localparam logic [CFG_A_W-1:0] REG_TIMEOUT_TICKS  = 2'd3;

  localparam logic [KIND_W-1:0] KIND_NEW    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RETX   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_STATUS = 2'd2;

  typedef struct packed {
    logic              ack_valid;
    logic [SEQ_W-1:0]  ack_seq;
    logic [TIME_W-1:0] now_time;
  } item_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SEQ_W-1:0]  seq_number;
    logic [WIN_W-1:0]  window_now;
    logic [CNT_W-1:0]  outstanding;
    logic [CNT_W-1:0]  timed_out_count;
    logic              done_res;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic [SEQ_W-1:0] total_chunks;
    logic [WIN_W-1:0] max_window;
    logic [TO_W-1:0]  timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic             load;
    logic [WIN_W-1:0] value;
  } win_load_t;

  typedef struct packed {
    logic empty;
  } fe_stat_t;

  function automatic logic [CNT_W-1:0] popcount(input logic [SLOTS-1:0] v);
    logic [CNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < SLOTS; i++) begin
      n = n + CNT_W'(v[i]);
    end
    return n;
  endfunction

endpackage

@@ rtl/srs_in_if.sv @@
// Input channel of the selective repeat sender: one round per beat.
// Depends on srs_pkg.
interface srs_in_if;
  logic                       valid;
  logic                       ready;
  logic                       ack_valid;
  logic [srs_pkg::SEQ_W-1:0]  ack_seq;
  logic [srs_pkg::TIME_W-1:0] now_time;

  modport source (output valid, ack_valid, ack_seq, now_time, input ready);
  modport sink   (input valid, ack_valid, ack_seq, now_time, output ready);
endinterface

@@ rtl/srs_out_if.sv @@
// Output channel of the selective repeat sender: sends, resends, status.
// Depends on srs_pkg.
interface srs_out_if;
  logic                       valid;
  logic                       ready;
  logic [srs_pkg::KIND_W-1:0] kind;
  logic [srs_pkg::SEQ_W-1:0]  seq_number;
  logic [srs_pkg::WIN_W-1:0]  window_now;
  logic [srs_pkg::CNT_W-1:0]  outstanding;
  logic [srs_pkg::CNT_W-1:0]  timed_out_count;
  logic                       done_res;
  logic                       last;

  modport source (output valid, kind, seq_number, window_now, outstanding,
                  timed_out_count, done_res, last, input ready);
  modport sink   (input valid, kind, seq_number, window_now, outstanding,
                  timed_out_count, done_res, last, output ready);
endinterface

@@ rtl/selective_repeat_sender_aimd.sv @@
// Selective repeat sender with additive-increase / halving window.
// in_i carries one round per beat: an optional ack and the current time.
// out_o returns, per round, an optional new send, then resends in order of
// age (oldest first, then lower sequence number), then one status beat with
// last set. Every beat of a round carries the end-of-round window,
// outstanding count, resend count and done flag.
// Configuration: cfg_we_i writes cfg_wdata_i to register cfg_idx_i
// (0 total chunks, 1 initial window, also loads the window, 2 max window,
// 3 timeout); write only while no round is in flight.
// Sequence: a round steps through dequeue, send, ack and timeout mark, then
// a new send beat if one was sent, then per resend a scan over the 32 slots
// (one slot per cycle) and the beat, then a scan that finds no resend left
// and the status beat; once done, only dequeue and status. A two-beat queue
// keeps taking rounds while the back end works, and a one-beat output
// register holds a result while the receiver stalls; the sequencer waits on
// it. Reset empties the slot table, the queue and the output, sets the window
// to 1 and the registers to 0 chunks, max window 32, timeout 2.
`include "selective_repeat_sender_aimd_defines.svh"

module selective_repeat_sender_aimd (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [srs_pkg::CFG_A_W-1:0]  cfg_idx_i,
  input  logic [srs_pkg::CFG_W-1:0]    cfg_wdata_i,
  srs_in_if.sink                       in_i,
  srs_out_if.source                    out_o
);

  srs_pkg::cfg_t       cfg_q;
  srs_pkg::win_load_t  win_load;
  srs_pkg::item_t      head;
  srs_pkg::fe_stat_t   fe_stat;
  logic                pop;
  logic [srs_pkg::WIN_W-1:0] wdata_win;

  assign wdata_win      = cfg_wdata_i[srs_pkg::WIN_W-1:0];
  assign win_load.load  = cfg_we_i && (cfg_idx_i == srs_pkg::REG_INITIAL_WINDOW);
  // a zero initial window loads as one
  assign win_load.value = (wdata_win == '0) ? srs_pkg::WIN_W'(1) : wdata_win;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.total_chunks  <= '0;
      cfg_q.max_window    <= srs_pkg::WIN_W'(32);
      cfg_q.timeout_ticks <= srs_pkg::TO_W'(2);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        srs_pkg::REG_TOTAL_CHUNKS:  cfg_q.total_chunks  <= cfg_wdata_i[srs_pkg::SEQ_W-1:0];
        srs_pkg::REG_MAX_WINDOW:    cfg_q.max_window    <= wdata_win;
        srs_pkg::REG_TIMEOUT_TICKS: cfg_q.timeout_ticks <= cfg_wdata_i[srs_pkg::TO_W-1:0];
        default: ;
      endcase
    end
  end

  srs_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .pop_i  (pop),
    .head_o (head),
    .stat_o (fe_stat)
  );

  srs_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .win_load_i (win_load),
    .head_i     (head),
    .fe_stat_i  (fe_stat),
    .pop_o      (pop),
    .out_o      (out_o)
  );

  `SRS_ASSERT_IMP(a_last_is_status, out_o.valid && out_o.last, out_o.kind == srs_pkg::KIND_STATUS, "last beat is not a status beat")
  `SRS_ASSERT_IMP(a_done_means_empty, out_o.valid && out_o.done_res, out_o.outstanding == '0, "done reported with packets outstanding")
  `SRS_ASSERT_IMP(a_outs_bound, out_o.valid, out_o.outstanding <= srs_pkg::CNT_W'(srs_pkg::SLOTS), "outstanding count above slot count")
  `SRS_ASSERT_NXT(a_accept_queued, in_i.valid && in_i.ready, !fe_stat.empty, "accepted round missing from queue")

endmodule

@@ rtl/srs_front.sv @@
// Front end: accepts round beats into a short queue for the back end.
// Depends on srs_pkg and srs_in_if.
module srs_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  srs_in_if.sink              in_i,
  input  logic                pop_i,
  output srs_pkg::item_t      head_o,
  output srs_pkg::fe_stat_t   stat_o
);

  srs_pkg::item_t                mem_q [srs_pkg::QDEPTH];
  logic [srs_pkg::QPTR_W-1:0]    wr_ptr_q, rd_ptr_q;
  logic [srs_pkg::QCNT_W-1:0]    count_q;
  logic                          push, pop;

  assign in_i.ready   = (count_q != srs_pkg::QCNT_W'(srs_pkg::QDEPTH));
  assign push         = in_i.valid && in_i.ready;
  assign pop          = pop_i && (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign stat_o.empty = (count_q == '0);

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= '{ack_valid: in_i.ack_valid, ack_seq: in_i.ack_seq,
                           now_time: in_i.now_time};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      case ({push, pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

@@ rtl/srs_back.sv @@
// Back end: slot table, round sequencer, resend ordering scan, output register.
// Depends on srs_pkg and srs_out_if.
module srs_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  srs_pkg::cfg_t        cfg_i,
  input  srs_pkg::win_load_t   win_load_i,
  input  srs_pkg::item_t       head_i,
  input  srs_pkg::fe_stat_t    fe_stat_i,
  output logic                 pop_o,
  srs_out_if.source            out_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SEND   = 3'd1;
  localparam logic [2:0] ST_ACK    = 3'd2;
  localparam logic [2:0] ST_MARK   = 3'd3;
  localparam logic [2:0] ST_NEW    = 3'd4;
  localparam logic [2:0] ST_SCAN   = 3'd5;
  localparam logic [2:0] ST_RETX   = 3'd6;
  localparam logic [2:0] ST_STATUS = 3'd7;

  localparam int unsigned SLOTS = srs_pkg::SLOTS;
  localparam int unsigned IDX_W = srs_pkg::IDX_W;

  logic [2:0]                   state_q;
  logic [srs_pkg::SEQ_W-1:0]    chunks_sent_q, next_seq_q;
  logic [srs_pkg::WIN_W-1:0]    win_q;
  logic [srs_pkg::CNT_W-1:0]    outs_q, timed_q;
  logic                         done_q;
  logic [SLOTS-1:0]             valid_q, mark_q;
  logic [srs_pkg::SEQ_W-1:0]    seq_q  [SLOTS];
  logic [srs_pkg::TIME_W-1:0]   time_q [SLOTS];
  logic                         ack_v_q;
  logic [srs_pkg::SEQ_W-1:0]    ack_seq_q;
  logic [srs_pkg::TIME_W-1:0]   now_q;
  logic                         sent_q;
  logic [srs_pkg::SEQ_W-1:0]    sent_seq_q;
  logic [IDX_W-1:0]             scan_idx_q, best_idx_q;
  logic [srs_pkg::TIME_W-1:0]   best_age_q;
  logic [srs_pkg::SEQ_W-1:0]    best_seq_q;
  logic                         have_best_q;
  logic                         o_valid_q;
  srs_pkg::out_item_t           o_item_q;

  logic                         out_free;
  logic                         emit;
  logic                         active;
  logic                         any_free;
  logic [IDX_W-1:0]             free_idx;
  logic                         send_ok;
  logic [SLOTS-1:0]             ack_hit, mark_now;
  logic [srs_pkg::CNT_W-1:0]    timed_now, outs_now;
  logic [srs_pkg::WIN_W-1:0]    win_next;
  logic [srs_pkg::TIME_W-1:0]   cur_age;
  logic                         cur_better;
  logic                         scan_last;

  assign out_free = !o_valid_q || out_o.ready;
  // a beat is loaded into the output register this cycle
  assign emit     = out_free && ((state_q == ST_NEW) || (state_q == ST_RETX) ||
                                 (state_q == ST_STATUS));
  assign active   = (chunks_sent_q < cfg_i.total_chunks) || (outs_q != '0);
  assign pop_o    = (state_q == ST_IDLE) && !fe_stat_i.empty;

  // lowest free slot
  always_comb begin
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid_q[i]) free_idx = IDX_W'(i);
    end
  end
  assign any_free = !(&valid_q);
  assign send_ok  = (chunks_sent_q < cfg_i.total_chunks) && (outs_q < win_q) && any_free;

  // per-slot ack match and timeout flag
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      ack_hit[i]  = valid_q[i] && (seq_q[i] == ack_seq_q);
      mark_now[i] = valid_q[i] &&
                    ((now_q - time_q[i]) >= srs_pkg::TIME_W'(cfg_i.timeout_ticks));
    end
  end
  assign timed_now = srs_pkg::popcount(mark_now);
  assign outs_now  = srs_pkg::popcount(valid_q);

  always_comb begin
    win_next = win_q;
    if (timed_now == '0) begin
      if (win_q < cfg_i.max_window) win_next = win_q + 1'b1;
    end else if (win_q > srs_pkg::WIN_W'(1)) begin
      win_next = win_q >> 1;
    end
  end

  // resend order: larger age first, then lower seq; equal keys keep lower index
  assign cur_age    = now_q - time_q[scan_idx_q];
  assign cur_better = mark_q[scan_idx_q] &&
                      (!have_best_q || (cur_age > best_age_q) ||
                       ((cur_age == best_age_q) && (seq_q[scan_idx_q] < best_seq_q)));
  assign scan_last  = (scan_idx_q == IDX_W'(SLOTS - 1));

  always_ff @(posedge clk_i) begin
    if (state_q == ST_SEND && send_ok) begin
      seq_q[free_idx]  <= next_seq_q;
      time_q[free_idx] <= now_q;
    end
    if (state_q == ST_RETX && out_free) begin
      time_q[best_idx_q] <= now_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_SCAN && cur_better) begin
      best_idx_q <= scan_idx_q;
      best_age_q <= cur_age;
      best_seq_q <= seq_q[scan_idx_q];
    end
    if (state_q == ST_IDLE && !fe_stat_i.empty) begin
      ack_v_q   <= head_i.ack_valid;
      ack_seq_q <= head_i.ack_seq;
      now_q     <= head_i.now_time;
    end
    if (state_q == ST_SEND) sent_seq_q <= next_seq_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      chunks_sent_q <= '0;
      next_seq_q    <= '0;
      win_q         <= srs_pkg::WIN_W'(1);
      outs_q        <= '0;
      timed_q       <= '0;
      done_q        <= 1'b0;
      valid_q       <= '0;
      mark_q        <= '0;
      sent_q        <= 1'b0;
      scan_idx_q    <= '0;
      have_best_q   <= 1'b0;
      o_valid_q     <= 1'b0;
      o_item_q      <= '0;
    end else begin
      if (emit) begin
        o_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        o_valid_q <= 1'b0;
      end
      if (win_load_i.load) win_q <= win_load_i.value;

      case (state_q)
        ST_IDLE: begin
          if (!fe_stat_i.empty) begin
            if (active) begin
              state_q <= ST_SEND;
            end else begin
              timed_q <= '0;
              done_q  <= 1'b1;
              state_q <= ST_STATUS;
            end
          end
        end
        ST_SEND: begin
          sent_q <= send_ok;
          if (send_ok) begin
            valid_q[free_idx] <= 1'b1;
            next_seq_q        <= next_seq_q + 1'b1;
            chunks_sent_q     <= chunks_sent_q + 1'b1;
          end
          state_q <= ST_ACK;
        end
        ST_ACK: begin
          if (ack_v_q) valid_q <= valid_q & ~ack_hit;
          state_q <= ST_MARK;
        end
        ST_MARK: begin
          mark_q      <= mark_now;
          timed_q     <= timed_now;
          outs_q      <= outs_now;
          win_q       <= win_next;
          done_q      <= (chunks_sent_q >= cfg_i.total_chunks) && (outs_now == '0);
          scan_idx_q  <= '0;
          have_best_q <= 1'b0;
          state_q     <= sent_q ? ST_NEW : ST_SCAN;
        end
        ST_NEW: begin
          if (out_free) begin
            o_item_q  <= '{kind: srs_pkg::KIND_NEW, seq_number: sent_seq_q,
                           window_now: win_q, outstanding: outs_q,
                           timed_out_count: timed_q, done_res: done_q, last: 1'b0};
            state_q   <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (mark_q == '0) begin
            state_q <= ST_STATUS;
          end else begin
            if (cur_better) have_best_q <= 1'b1;
            scan_idx_q <= scan_idx_q + 1'b1;
            if (scan_last) state_q <= ST_RETX;
          end
        end
        ST_RETX: begin
          if (out_free) begin
            o_item_q           <= '{kind: srs_pkg::KIND_RETX, seq_number: best_seq_q,
                                    window_now: win_q, outstanding: outs_q,
                                    timed_out_count: timed_q, done_res: done_q,
                                    last: 1'b0};
            mark_q[best_idx_q] <= 1'b0;
            scan_idx_q         <= '0;
            have_best_q        <= 1'b0;
            state_q            <= ST_SCAN;
          end
        end
        ST_STATUS: begin
          if (out_free) begin
            o_item_q  <= '{kind: srs_pkg::KIND_STATUS, seq_number: '0,
                           window_now: win_q, outstanding: outs_q,
                           timed_out_count: timed_q, done_res: done_q, last: 1'b1};
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_o.valid           = o_valid_q;
  assign out_o.kind            = o_item_q.kind;
  assign out_o.seq_number      = o_item_q.seq_number;
  assign out_o.window_now      = o_item_q.window_now;
  assign out_o.outstanding     = o_item_q.outstanding;
  assign out_o.timed_out_count = o_item_q.timed_out_count;
  assign out_o.done_res        = o_item_q.done_res;
  assign out_o.last            = o_item_q.last;

endmodule

@@ sim/testbench.sv @@
// Testbench for selective_repeat_sender_aimd: a directed table of rounds and
// register writes, then random phases, every output beat checked in order.
// Depends on srs_pkg, srs_in_if, srs_out_if and the RTL top module.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import srs_pkg::*;

  localparam int SETTLE_CYCLES = 10;
  localparam int NUM_PHASES    = 7;

  typedef enum logic [1:0] {ROW_CFG, ROW_ROUND, ROW_TYPED} row_op_e;

  typedef struct {
    row_op_e            op;
    logic [CFG_A_W-1:0] idx;
    logic [CFG_W-1:0]   wdata;
    item_t              rnd;
    bit                 sends;
    logic [SEQ_W-1:0]   sent_seq;
    logic [WIN_W-1:0]   win;
    logic [CNT_W-1:0]   outs;
    logic               done;
  } row_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_we;
  logic [CFG_A_W-1:0] cfg_idx;
  logic [CFG_W-1:0]   cfg_wdata;

  srs_in_if  in_ch ();
  srs_out_if out_ch ();

  selective_repeat_sender_aimd dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  always #1 clk = ~clk;

  // sender model state and register copies
  logic [SEQ_W-1:0]  cfg_total;
  logic [WIN_W-1:0]  cfg_max_win;
  logic [TO_W-1:0]   cfg_rto;
  logic [SEQ_W-1:0]  chunks_out;
  logic [SEQ_W-1:0]  seq_next;
  logic [WIN_W-1:0]  cwnd;
  bit                slot_busy [SLOTS];
  logic [SEQ_W-1:0]  slot_seq_q [SLOTS];
  logic [TIME_W-1:0] slot_stamp [SLOTS];

  out_item_t   round_beats[$];
  out_item_t   beats_due[$];
  row_t        script[$];
  int          mismatches = 0;
  int          burst_left = 0;
  int unsigned stall_tick = 0;
  logic [TIME_W-1:0] wall;

  function automatic int busy_slots();
    int n;
    n = 0;
    for (int i = 0; i < SLOTS; i++) if (slot_busy[i]) n++;
    return n;
  endfunction

  // oldest stamp first, then lower sequence number, then lower slot
  function automatic bit resend_before(int a, int b, logic [TIME_W-1:0] now);
    logic [TIME_W-1:0] age_a;
    logic [TIME_W-1:0] age_b;
    age_a = now - slot_stamp[a];
    age_b = now - slot_stamp[b];
    if (age_a != age_b) return age_a > age_b;
    if (slot_seq_q[a] != slot_seq_q[b]) return slot_seq_q[a] < slot_seq_q[b];
    return a < b;
  endfunction

  function automatic void load_reg(logic [CFG_A_W-1:0] idx, logic [CFG_W-1:0] data);
    case (idx)
      REG_TOTAL_CHUNKS:   cfg_total = data;
      REG_INITIAL_WINDOW: cwnd = (data[WIN_W-1:0] == '0) ? WIN_W'(1) : data[WIN_W-1:0];
      REG_MAX_WINDOW:     cfg_max_win = data[WIN_W-1:0];
      REG_TIMEOUT_TICKS:  cfg_rto = data[TO_W-1:0];
      default: ;
    endcase
  endfunction

  // one sender round: new send, ack, timeout scan, window update
  function automatic void arq_round(item_t rnd);
    int                outs;
    int                order[$];
    int                pos;
    logic [KIND_W-1:0] kinds[$];
    logic [SEQ_W-1:0]  seqs[$];
    logic [TIME_W-1:0] age;
    out_item_t         b;
    logic              done;
    round_beats.delete();
    outs = busy_slots();
    if (chunks_out < cfg_total || outs != 0) begin
      if (chunks_out < cfg_total && outs < int'(cwnd)) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (!slot_busy[i]) begin
            slot_busy[i]  = 1'b1;
            slot_seq_q[i] = seq_next;
            slot_stamp[i] = rnd.now_time;
            kinds.push_back(KIND_NEW);
            seqs.push_back(seq_next);
            seq_next++;
            chunks_out++;
            break;
          end
        end
      end
      if (rnd.ack_valid) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_busy[i] && slot_seq_q[i] == rnd.ack_seq) slot_busy[i] = 1'b0;
        end
      end
      for (int i = 0; i < SLOTS; i++) begin
        age = rnd.now_time - slot_stamp[i];
        if (slot_busy[i] && age >= TIME_W'(cfg_rto)) begin
          pos = order.size();
          while (pos > 0 && resend_before(i, order[pos-1], rnd.now_time)) pos--;
          order.insert(pos, i);
        end
      end
      foreach (order[k]) begin
        kinds.push_back(KIND_RETX);
        seqs.push_back(slot_seq_q[order[k]]);
        slot_stamp[order[k]] = rnd.now_time;
      end
      if (order.size() == 0) begin
        if (cwnd < cfg_max_win) cwnd++;
      end else if (cwnd > 1) begin
        cwnd = cwnd >> 1;
      end
      outs = busy_slots();
    end
    kinds.push_back(KIND_STATUS);
    seqs.push_back('0);
    done = (chunks_out >= cfg_total) && (outs == 0);
    foreach (kinds[k]) begin
      b.kind            = kinds[k];
      b.seq_number      = seqs[k];
      b.window_now      = cwnd;
      b.outstanding     = CNT_W'(outs);
      b.timed_out_count = CNT_W'(order.size());
      b.done_res        = done;
      b.last            = (k == kinds.size() - 1);
      round_beats.push_back(b);
    end
  endfunction

  function automatic out_item_t typed_beat(row_t r, logic [KIND_W-1:0] kind);
    out_item_t b;
    b.kind            = kind;
    b.seq_number      = (kind == KIND_NEW) ? r.sent_seq : '0;
    b.window_now      = r.win;
    b.outstanding     = r.outs;
    b.timed_out_count = '0;
    b.done_res        = r.done;
    b.last            = (kind == KIND_STATUS);
    return b;
  endfunction

  function automatic void add_cfg(logic [CFG_A_W-1:0] idx, logic [CFG_W-1:0] data);
    row_t r;
    r.op    = ROW_CFG;
    r.idx   = idx;
    r.wdata = data;
    script.push_back(r);
  endfunction

  function automatic void add_round(logic av, logic [SEQ_W-1:0] ack, logic [TIME_W-1:0] now);
    row_t r;
    r.op            = ROW_ROUND;
    r.rnd.ack_valid = av;
    r.rnd.ack_seq   = ack;
    r.rnd.now_time  = now;
    r.sends         = 1'b0;
    script.push_back(r);
  endfunction

  // fixes the outcome of the round just added: optional new send, then status
  function automatic void ends_with(bit sends, logic [SEQ_W-1:0] sent_seq,
                                    logic [WIN_W-1:0] win, logic [CNT_W-1:0] outs,
                                    logic done);
    row_t r;
    r          = script.pop_back();
    r.op       = ROW_TYPED;
    r.sends    = sends;
    r.sent_seq = sent_seq;
    r.win      = win;
    r.outs     = outs;
    r.done     = done;
    script.push_back(r);
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  task automatic drive_round(item_t rnd);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
      gap = $urandom_range(0, 5);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_ch.valid     <= 1'b1;
    in_ch.ack_valid <= rnd.ack_valid;
    in_ch.ack_seq   <= rnd.ack_seq;
    in_ch.now_time  <= rnd.now_time;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
  endtask

  task automatic run_round(item_t rnd);
    drive_round(rnd);
    arq_round(rnd);
    beats_due = {beats_due, round_beats};
  endtask

  // hold the input off until every beat due has come out
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (beats_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_A_W-1:0] idx, logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    load_reg(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_round(int ack_pct, int jump_pct);
    item_t rnd;
    int    live[$];
    int    roll;
    for (int i = 0; i < SLOTS; i++) if (slot_busy[i]) live.push_back(i);
    roll          = $urandom_range(0, 99);
    rnd.ack_valid = 1'b1;
    rnd.ack_seq   = $urandom();
    if (roll < ack_pct && live.size() != 0) begin
      rnd.ack_seq = slot_seq_q[live[$urandom_range(0, live.size() - 1)]];
    end else if (roll < ack_pct + 5) begin
      // ack for the packet this same round may send
      rnd.ack_seq = seq_next;
    end else if (roll >= 85) begin
      rnd.ack_valid = 1'b0;
    end
    if ($urandom_range(0, 99) < jump_pct) wall = wall + $urandom();
    else wall = wall + $urandom_range(0, 2);
    rnd.now_time = wall;
    run_round(rnd);
  endtask

  always @(negedge clk) begin
    stall_tick <= stall_tick + 1;
    case (stall_tick[8:7])
      2'd0:    out_ch.ready <= 1'b1;
      2'd1:    out_ch.ready <= ($urandom_range(0, 9) < 7);
      2'd2:    out_ch.ready <= (stall_tick[1:0] == 2'd0);
      default: out_ch.ready <= $urandom_range(0, 1);
    endcase
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (beats_due.size() == 0) begin
        $display("%0t: expected no beat, got kind %0d seq %0d", $time, out_ch.kind,
                 out_ch.seq_number);
        mismatches++;
      end else begin
        want = beats_due.pop_front();
        check_field("kind", want.kind, out_ch.kind);
        check_field("seq_number", want.seq_number, out_ch.seq_number);
        check_field("window_now", want.window_now, out_ch.window_now);
        check_field("outstanding", want.outstanding, out_ch.outstanding);
        check_field("timed_out_count", want.timed_out_count, out_ch.timed_out_count);
        check_field("done_res", want.done_res, out_ch.done_res);
        check_field("last", want.last, out_ch.last);
      end
    end
  end

  initial begin
    logic [CFG_W-1:0] total;
    int               iw;
    int               mw;
    int               rto;
    int               ack_pct;
    int               jump_pct;
    int               rounds;

    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = '0;
    cfg_wdata       = '0;
    in_ch.valid     = 1'b0;
    in_ch.ack_valid = 1'b0;
    in_ch.ack_seq   = '0;
    in_ch.now_time  = '0;
    out_ch.ready    = 1'b0;
    cfg_total       = '0;
    cfg_max_win     = WIN_W'(32);
    cfg_rto         = TO_W'(2);
    chunks_out      = '0;
    seq_next        = '0;
    cwnd            = WIN_W'(1);
    wall            = '0;
    foreach (slot_busy[i]) slot_busy[i] = 1'b0;

    // nothing to send after reset: status only, no state change
    add_round(1'b0, 32'h0, 32'h0);                ends_with(0, 0, 1, 0, 1);
    add_round(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF); ends_with(0, 0, 1, 0, 1);
    // three chunks, zero initial window loads 1, timeout at its top
    add_cfg(REG_TOTAL_CHUNKS, 32'd3);
    add_cfg(REG_INITIAL_WINDOW, 32'd0);
    add_cfg(REG_TIMEOUT_TICKS, 32'h0000_FFFF);
    add_round(1'b0, 32'h0, 32'd100);         ends_with(1, 0, 2, 1, 0);
    add_round(1'b0, 32'h0, 32'd101);         ends_with(1, 1, 3, 2, 0);
    add_round(1'b1, 32'h0, 32'd102);         ends_with(1, 2, 4, 2, 0);
    add_round(1'b1, 32'h1234_5678, 32'd103); ends_with(0, 0, 5, 2, 0);
    add_round(1'b1, 32'h1, 32'd104);         ends_with(0, 0, 6, 1, 0);
    add_round(1'b1, 32'h2, 32'd105);         ends_with(0, 0, 7, 0, 1);
    add_round(1'b0, 32'h0, 32'd106);         ends_with(0, 0, 7, 0, 1);
    // zero timeout resends the packet just sent; time wraps
    add_cfg(REG_TOTAL_CHUNKS, 32'hFFFF_FFFF);
    add_cfg(REG_TIMEOUT_TICKS, 32'd0);
    add_cfg(REG_INITIAL_WINDOW, 32'd2);
    add_round(1'b0, 32'h0, 32'd200);
    add_round(1'b0, 32'h0, 32'hFFFF_FFF0);
    add_round(1'b1, 32'h3, 32'd5);
    // window above the limit, then timeouts with equal and unequal stamps
    add_cfg(REG_TIMEOUT_TICKS, 32'd3);
    add_cfg(REG_MAX_WINDOW, 32'd2);
    add_cfg(REG_INITIAL_WINDOW, 32'd63);
    add_round(1'b0, 32'h0, 32'd10);
    add_round(1'b0, 32'h0, 32'd11);
    add_round(1'b0, 32'h0, 32'd12);
    add_round(1'b0, 32'h0, 32'd13);
    add_round(1'b1, 32'h5, 32'd15);
    add_round(1'b0, 32'h0, 32'd16);
    add_round(1'b0, 32'h0, 32'd30);
    // total cut below what was already sent
    add_cfg(REG_TOTAL_CHUNKS, 32'd2);
    add_round(1'b1, 32'h6, 32'd31);
    add_round(1'b1, 32'h8, 32'd33);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (script[i]) begin
      if (script[i].op == ROW_CFG) begin
        settle();
        write_reg(script[i].idx, script[i].wdata);
      end else if (script[i].op == ROW_TYPED) begin
        drive_round(script[i].rnd);
        arq_round(script[i].rnd);
        if (script[i].sends) beats_due.push_back(typed_beat(script[i], KIND_NEW));
        beats_due.push_back(typed_beat(script[i], KIND_STATUS));
      end else begin
        run_round(script[i].rnd);
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      rounds   = 18;
      jump_pct = 4;
      case (ph)
        0: begin
          total = chunks_out + 30; iw = 4; mw = 32; rto = $urandom_range(2, 5);
          ack_pct = 65;
        end
        1: begin
          // few acks and no timeouts: the slot table fills up
          total = '1; iw = 63; mw = 63; rto = 16'hFFFF; ack_pct = 5;
          jump_pct = 0; rounds = 36;
        end
        2: begin
          // every outstanding packet resent every round
          total = chunks_out + 4; iw = 63; mw = 0; rto = 0; ack_pct = 70;
        end
        3: begin
          total = chunks_out + $urandom_range(0, 20); iw = $urandom_range(0, 63);
          mw = $urandom_range(1, 63); rto = $urandom_range(1, 8); ack_pct = 60;
        end
        4: begin
          total = chunks_out >> 1; iw = 32; mw = 32; rto = $urandom_range(0, 16'hFFFF);
          ack_pct = 60; jump_pct = 10;
        end
        5: begin
          total = '0; iw = 1; mw = 1; rto = 1; ack_pct = 50;
        end
        default: begin
          total = chunks_out + 40; iw = $urandom_range(0, 63); mw = $urandom_range(0, 63);
          rto = $urandom_range(1, 6); ack_pct = 60;
        end
      endcase
      write_reg(REG_TOTAL_CHUNKS, total);
      write_reg(REG_INITIAL_WINDOW, CFG_W'(iw));
      write_reg(REG_MAX_WINDOW, CFG_W'(mw));
      write_reg(REG_TIMEOUT_TICKS, CFG_W'(rto));
      wall = $urandom();
      repeat (rounds) random_round(ack_pct, jump_pct);
    end

    settle();
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/srs_pkg.sv
rtl/srs_in_if.sv
rtl/srs_out_if.sv
rtl/srs_front.sv
rtl/srs_back.sv
rtl/selective_repeat_sender_aimd.sv
sim/testbench.sv
